FILE: design/olad_pkg.sv
`timescale 1ns / 1ps
// olad_pkg: shared constants and types for the ordered list block.
// Used by olad_store, olad_ctrl and ordered_list_append_delete_top; no dependencies.
package olad_pkg;

	localparam int CAPACITY_DEF = 32;
	localparam int DATA_W       = 32;

	// operation codes on the mode field
	localparam logic [1:0] MODE_INSERT   = 2'd0;
	localparam logic [1:0] MODE_DELETE   = 2'd1;
	localparam logic [1:0] MODE_TRAVERSE = 2'd2;

	// result status codes
	localparam logic [2:0] STAT_INSERTED  = 3'd0;
	localparam logic [2:0] STAT_DELETED   = 3'd1;
	localparam logic [2:0] STAT_NOT_FOUND = 3'd2;
	localparam logic [2:0] STAT_EMPTY     = 3'd3;
	localparam logic [2:0] STAT_FULL      = 3'd4;
	localparam logic [2:0] STAT_ELEMENT   = 3'd5;

	// memory port enables from the controller
	typedef struct packed {
		logic we;
		logic re;
	} mem_en_t;

endpackage

FILE: design/ordered_list_append_delete_top.sv
`timescale 1ns / 1ps
// ordered_list_append_delete_top: bounded ordered list of signed 32-bit values.
// Depends on olad_pkg, olad_ctrl and olad_store.

// The block keeps up to CAPACITY signed 32-bit values in arrival order in a
// single memory (one write port, one read port, registered read data); the
// entries hold no reset value, while reset clears the entry count, the state
// and the output valid. mode 0 appends value at the tail (status inserted, or
// full when the list already holds CAPACITY entries); mode 1 removes the oldest
// entry equal to value and closes the gap (deleted, not found, or empty); mode 2
// emits every stored value oldest first with status element and last on the
// final one, or a single empty result. Mode 3 is taken and produces nothing.
// Every transaction on the output carries last, which is high on the final
// result of an input transaction. Sequencing: an insert, or a delete or
// traverse of an empty list, passes to a response state and its result loads
// into the output register once that register is free; mode 3 leaves the
// sequencer free at once. A delete on a list of N entries streams through the
// memory's read port, one entry per cycle, while compacting through the write
// port behind the read, then passes its result to the response state. A
// traverse reads each entry and then loads it into the output register, waiting
// there while the output is stalled. Throughput is thus bound by the single
// read port. in_stall is high while an operation is in progress; a finished
// result can wait in the output register while the next transaction is
// accepted.
module ordered_list_append_delete_top #(
	parameter int CAPACITY = olad_pkg::CAPACITY_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          mode,
	input  logic signed [olad_pkg::DATA_W-1:0]  value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [2:0]                          status,
	output logic signed [olad_pkg::DATA_W-1:0]  element,
	output logic                                last
);

	localparam int IDX_W = $clog2(CAPACITY);

	// memory request from the sequencer
	olad_pkg::mem_en_t            mem_en;
	logic [IDX_W-1:0]             mem_waddr;
	logic [olad_pkg::DATA_W-1:0]  mem_wdata;
	logic [IDX_W-1:0]             mem_raddr;
	logic [olad_pkg::DATA_W-1:0]  mem_rdata;

	// sequencer: count, scan/compaction, traverse, output register
	olad_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.element   (element),
		.last      (last),
		.mem_en    (mem_en),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// entry storage
	olad_store #(
		.CAPACITY (CAPACITY)
	) u_store (
		.clk   (clk),
		.en    (mem_en),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

FILE: design/olad_store.sv
`timescale 1ns / 1ps
// olad_store: entry memory, one write port and one read port, registered read data.
// Depends on olad_pkg.
module olad_store #(
	parameter int CAPACITY = olad_pkg::CAPACITY_DEF,
	localparam int IDX_W   = $clog2(CAPACITY)
) (
	input  logic                         clk,
	input  olad_pkg::mem_en_t            en,
	input  logic [IDX_W-1:0]             waddr,
	input  logic [olad_pkg::DATA_W-1:0]  wdata,
	input  logic [IDX_W-1:0]             raddr,
	output logic [olad_pkg::DATA_W-1:0]  rdata
);

	logic [olad_pkg::DATA_W-1:0] entries_q [CAPACITY];
	logic [olad_pkg::DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (en.we) begin
			entries_q[waddr] <= wdata;
		end
		// read data holds until the next read
		if (en.re) begin
			rd_data_q <= entries_q[raddr];
		end
	end

	assign rdata = rd_data_q;

endmodule

FILE: design/olad_ctrl.sv
`timescale 1ns / 1ps
// olad_ctrl: operation sequencer, entry count, delete scan/compaction and output register.
// Depends on olad_pkg; drives the ports of olad_store.
module olad_ctrl #(
	parameter int CAPACITY = olad_pkg::CAPACITY_DEF,
	localparam int IDX_W   = $clog2(CAPACITY),
	localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          mode,
	input  logic signed [olad_pkg::DATA_W-1:0]  value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [2:0]                          status,
	output logic signed [olad_pkg::DATA_W-1:0]  element,
	output logic                                last,
	output olad_pkg::mem_en_t                   mem_en,
	output logic [IDX_W-1:0]                    mem_waddr,
	output logic [olad_pkg::DATA_W-1:0]         mem_wdata,
	output logic [IDX_W-1:0]                    mem_raddr,
	input  logic [olad_pkg::DATA_W-1:0]         mem_rdata
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DEL,
		S_TRD,
		S_TOUT,
		S_RESP
	} state_t;

	state_t                       state_q;
	logic [CNT_W-1:0]             count_q;
	logic [CNT_W-1:0]             rd_idx_q;
	logic [IDX_W-1:0]             idx_s1;
	logic                         vld_s1;
	logic                         found_q;
	logic [olad_pkg::DATA_W-1:0]  val_q;
	logic [2:0]                   resp_q;
	logic                         out_valid_q;
	logic [2:0]                   status_q;
	logic [olad_pkg::DATA_W-1:0]  element_q;
	logic                         last_q;

	logic accept;
	logic out_free;
	logic out_load;
	logic full;
	logic empty;
	logic issue;
	logic trav_last;

	assign accept    = in_valid && (state_q == S_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign out_load  = out_free && ((state_q == S_TOUT) || (state_q == S_RESP));
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign empty     = (count_q == '0);
	assign issue     = (rd_idx_q < count_q);
	assign trav_last = ((rd_idx_q + CNT_W'(1)) == count_q);

	// memory requests: insert writes at the tail, compaction writes one slot down
	always_comb begin
		mem_en.we = 1'b0;
		mem_en.re = 1'b0;
		mem_waddr = count_q[IDX_W-1:0];
		mem_wdata = value;
		mem_raddr = rd_idx_q[IDX_W-1:0];
		if (state_q == S_DEL) begin
			mem_en.we = vld_s1 && found_q;
			mem_en.re = issue;
			mem_waddr = idx_s1 - IDX_W'(1);
			mem_wdata = mem_rdata;
		end else if (state_q == S_TRD) begin
			mem_en.re = 1'b1;
		end else if (accept && (mode == olad_pkg::MODE_INSERT) && !full) begin
			mem_en.we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rd_idx_q    <= '0;
			vld_s1      <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (mode)
							olad_pkg::MODE_INSERT: begin
								if (full) begin
									resp_q <= olad_pkg::STAT_FULL;
								end else begin
									count_q <= count_q + CNT_W'(1);
									resp_q  <= olad_pkg::STAT_INSERTED;
								end
								state_q <= S_RESP;
							end
							olad_pkg::MODE_DELETE: begin
								if (empty) begin
									resp_q  <= olad_pkg::STAT_EMPTY;
									state_q <= S_RESP;
								end else begin
									val_q    <= value;
									rd_idx_q <= '0;
									found_q  <= 1'b0;
									vld_s1   <= 1'b0;
									state_q  <= S_DEL;
								end
							end
							olad_pkg::MODE_TRAVERSE: begin
								if (empty) begin
									resp_q  <= olad_pkg::STAT_EMPTY;
									state_q <= S_RESP;
								end else begin
									rd_idx_q <= '0;
									state_q  <= S_TRD;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_DEL: begin
					// read k while comparing or shifting k-1
					vld_s1 <= issue;
					idx_s1 <= rd_idx_q[IDX_W-1:0];
					if (issue) begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
					end
					if (vld_s1 && !found_q && (mem_rdata == val_q)) begin
						found_q <= 1'b1;
					end
					if (!issue && !vld_s1) begin
						if (found_q) begin
							count_q <= count_q - CNT_W'(1);
							resp_q  <= olad_pkg::STAT_DELETED;
						end else begin
							resp_q  <= olad_pkg::STAT_NOT_FOUND;
						end
						state_q <= S_RESP;
					end
				end
				S_TRD: begin
					state_q <= S_TOUT;
				end
				S_TOUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						status_q    <= olad_pkg::STAT_ELEMENT;
						element_q   <= mem_rdata;
						last_q      <= trav_last;
						rd_idx_q    <= rd_idx_q + CNT_W'(1);
						state_q     <= trav_last ? S_IDLE : S_TRD;
					end
				end
				S_RESP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						status_q    <= resp_q;
						element_q   <= '0;
						last_q      <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign element   = element_q;
	assign last      = last_q;

endmodule

FILE: test/ordered_list_append_delete_top_tb.sv
`timescale 1ns / 1ps
// ordered_list_append_delete_top_tb: self-checking bench for the bounded ordered list.
// Depends on olad_pkg and ordered_list_append_delete_top; stands alone otherwise.
module ordered_list_append_delete_top_tb;

	localparam int LIST_CAP     = olad_pkg::CAPACITY_DEF;
	localparam int RAND_ITEMS   = 300;
	localparam int QUIET_TAIL   = 40;      // last pending items run with no idling
	localparam int DRAIN_CYCLES = 200;
	localparam int DRAIN_LIMIT  = 20000;
	localparam int CYCLE_LIMIT  = 600000;

	// mode 3 is not an operation; the block must take it and emit nothing
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef logic signed [olad_pkg::DATA_W-1:0] word_t;

	typedef struct {
		logic [1:0] op;
		word_t      val;
	} list_req_t;

	typedef struct {
		logic [2:0] status;
		word_t      element;
		logic       last;
	} list_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] mode = olad_pkg::MODE_INSERT;
	word_t      value = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [2:0] status;
	word_t      element;
	logic       last;

	// request stream, shadow of the list contents, results still owed by the block
	list_req_t    pending_reqs[$];
	word_t        list_shadow[$];
	list_result_t expected_results[$];
	word_t        value_pool[8];

	int total_reqs;
	int accepted_cnt = 0;
	int issued_cnt = 0;
	int in_gap = 0;
	int out_gap = 0;
	int errors = 0;
	int cycle_cnt = 0;
	list_req_t drv_req;
	list_result_t mon_exp;

	ordered_list_append_delete_top #(
		.CAPACITY(LIST_CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.element(element),
		.last(last)
	);

	always #6 clk = ~clk;

	task automatic report_mismatch(input string msg);
		errors++;
		$display("%0t ns: mismatch: %s", $time, msg);
	endtask

	task automatic add_req(input logic [1:0] op, input word_t val);
		list_req_t r;
		r.op = op;
		r.val = val;
		pending_reqs.push_back(r);
	endtask

	// delete hits need repeated values, so most operands come from a small pool
	function automatic word_t pick_value();
		word_t v;
		if ($urandom_range(0, 9) < 7)
			v = value_pool[$urandom_range(0, 7)];
		else
			v = $urandom;
		return v;
	endfunction

	function automatic void owe_result(input logic [2:0] st, input word_t el, input logic lst);
		list_result_t r;
		r.status = st;
		r.element = el;
		r.last = lst;
		expected_results.push_back(r);
	endfunction

	// Applies one accepted transaction to the shadow list and queues what the
	// block owes for it.
	task automatic apply_list_op(input logic [1:0] op, input word_t val);
		int hit;
		hit = -1;
		case (op)
			olad_pkg::MODE_INSERT: begin
				if (list_shadow.size() >= LIST_CAP) begin
					owe_result(olad_pkg::STAT_FULL, '0, 1'b1);
				end else begin
					list_shadow.push_back(val);
					owe_result(olad_pkg::STAT_INSERTED, '0, 1'b1);
				end
			end
			olad_pkg::MODE_DELETE: begin
				if (list_shadow.size() == 0) begin
					owe_result(olad_pkg::STAT_EMPTY, '0, 1'b1);
				end else begin
					// only the oldest equal entry goes
					for (int i = 0; i < list_shadow.size(); i++)
						if (hit < 0 && list_shadow[i] == val)
							hit = i;
					if (hit >= 0) begin
						list_shadow.delete(hit);
						owe_result(olad_pkg::STAT_DELETED, '0, 1'b1);
					end else begin
						owe_result(olad_pkg::STAT_NOT_FOUND, '0, 1'b1);
					end
				end
			end
			olad_pkg::MODE_TRAVERSE: begin
				if (list_shadow.size() == 0)
					owe_result(olad_pkg::STAT_EMPTY, '0, 1'b1);
				else
					for (int i = 0; i < list_shadow.size(); i++)
						owe_result(olad_pkg::STAT_ELEMENT, list_shadow[i],
							i == list_shadow.size() - 1);
			end
			default: ;
		endcase
	endtask

	// Input driver: a presented transaction is held until the monitor counts it
	// as accepted; between transactions it may idle for a random burst.
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && accepted_cnt != issued_cnt) begin
				// still waiting for acceptance, payload held
			end else if (in_gap != 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (pending_reqs.size() != 0) begin
				drv_req = pending_reqs.pop_front();
				mode <= drv_req.op;
				value <= drv_req.val;
				in_valid <= 1'b1;
				issued_cnt++;
				if (pending_reqs.size() >= QUIET_TAIL && $urandom_range(0, 4) == 0)
					in_gap = $urandom_range(1, 6);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Output back-pressure in bursts, switched off near the end of the stream.
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_gap != 0) begin
				out_gap--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				if (pending_reqs.size() >= QUIET_TAIL && $urandom_range(0, 5) == 0)
					out_gap = $urandom_range(1, 6);
			end
		end
	end

	// Monitor: predicts on each input transaction, checks each output transaction
	// against the oldest owed result.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				apply_list_op(mode, value);
				accepted_cnt <= accepted_cnt + 1;
			end
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result status=%0d element=%0d last=%b",
						status, element, last));
				end else begin
					mon_exp = expected_results.pop_front();
					if (status !== mon_exp.status)
						report_mismatch($sformatf("status got %0d want %0d",
							status, mon_exp.status));
					if (element !== mon_exp.element)
						report_mismatch($sformatf("element got %0d want %0d",
							element, mon_exp.element));
					if (last !== mon_exp.last)
						report_mismatch($sformatf("last got %b want %b",
							last, mon_exp.last));
				end
			end
		end
	end

	// Hang guard.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int kind;
		int len;
		int r;
		int n_rand;
		int waited;
		logic [1:0] op;

		value_pool[0] = 32'sh8000_0000;
		value_pool[1] = 32'sh7FFF_FFFF;
		value_pool[2] = 32'sd0;
		value_pool[3] = -32'sd1;
		for (int i = 4; i < 8; i++)
			value_pool[i] = $urandom;

		// directed: empty list, extremes, duplicates, head/tail/middle deletes
		add_req(olad_pkg::MODE_TRAVERSE, 32'sh7FFF_FFFF);   // traverse of empty list
		add_req(olad_pkg::MODE_DELETE, 32'sd5);             // delete from empty list
		add_req(MODE_UNUSED, 32'sh8000_0000);               // ignored, no result
		add_req(olad_pkg::MODE_INSERT, 32'sh8000_0000);
		add_req(olad_pkg::MODE_INSERT, 32'sh7FFF_FFFF);
		add_req(olad_pkg::MODE_INSERT, 32'sd0);
		add_req(olad_pkg::MODE_INSERT, -32'sd1);
		add_req(olad_pkg::MODE_INSERT, 32'sh7FFF_FFFF);     // duplicate
		add_req(olad_pkg::MODE_INSERT, 32'sd1);
		add_req(olad_pkg::MODE_TRAVERSE, 32'sd0);
		add_req(olad_pkg::MODE_DELETE, 32'sh7FFF_FFFF);     // must take the older copy
		add_req(olad_pkg::MODE_DELETE, 32'sd12345);         // no match
		add_req(olad_pkg::MODE_TRAVERSE, -32'sd1);
		add_req(MODE_UNUSED, $urandom);
		add_req(olad_pkg::MODE_DELETE, 32'sh8000_0000);     // head
		add_req(olad_pkg::MODE_DELETE, 32'sd1);             // tail
		add_req(olad_pkg::MODE_DELETE, 32'sh7FFF_FFFF);
		add_req(olad_pkg::MODE_TRAVERSE, 32'sd0);
		add_req(olad_pkg::MODE_DELETE, 32'sd0);
		add_req(olad_pkg::MODE_DELETE, -32'sd1);
		add_req(olad_pkg::MODE_DELETE, -32'sd1);            // list already empty
		add_req(olad_pkg::MODE_TRAVERSE, 32'sd0);

		// first random episode fills past capacity so full and full traverse occur
		for (int i = 0; i < LIST_CAP + 2; i++)
			add_req(olad_pkg::MODE_INSERT, pick_value());
		add_req(olad_pkg::MODE_TRAVERSE, $urandom);
		n_rand = LIST_CAP + 3;

		// then episodes biased toward filling, draining or a mix
		while (n_rand < RAND_ITEMS) begin
			kind = $urandom_range(0, 2);
			len = $urandom_range(10, 40);
			for (int k = 0; k < len; k++) begin
				r = $urandom_range(0, 99);
				if (r < 2)
					op = MODE_UNUSED;
				else if (r < 10)
					op = olad_pkg::MODE_TRAVERSE;
				else if (kind == 0)
					op = (r < 91) ? olad_pkg::MODE_INSERT : olad_pkg::MODE_DELETE;
				else if (kind == 1)
					op = (r < 82) ? olad_pkg::MODE_DELETE : olad_pkg::MODE_INSERT;
				else
					op = (r < 55) ? olad_pkg::MODE_INSERT : olad_pkg::MODE_DELETE;
				if (op == olad_pkg::MODE_INSERT || op == olad_pkg::MODE_DELETE)
					add_req(op, pick_value());
				else
					add_req(op, $urandom);
				if (op != MODE_UNUSED)
					n_rand++;
			end
		end
		total_reqs = pending_reqs.size();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (accepted_cnt != total_reqs)
			@(negedge clk);
		waited = 0;
		while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		if (expected_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
		// anything the block emits after this point is flagged by the monitor
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: sim.f
design/olad_pkg.sv
design/olad_store.sv
design/olad_ctrl.sv
design/ordered_list_append_delete_top.sv
test/ordered_list_append_delete_top_tb.sv
